// ===== rtl/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// shared sequencer state type for the single-source shortest path block
// ----------------------------------------------------------------------------
package ssp_pkg;

    // sequencer states of the search engine
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_START,
        ST_POP,
        ST_POP_WAIT,
        ST_DIST_U,
        ST_SCAN,
        ST_EVAL,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_HOLD
    } state_t;

endpackage

// ===== rtl/ssp_ram.sv =====
// ----------------------------------------------------------------------------
// ssp_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module ssp_ram
    import ssp_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/single_source_shortest_path_pape.sv =====
// ----------------------------------------------------------------------------
// single_source_shortest_path_pape
// D'Esopo-Pape shortest-path search over a loaded adjacency matrix
// ----------------------------------------------------------------------------
// The block takes adjacency-matrix entries on the slave stream, one transaction
// per cycle while s_tready is high; an entry with row below column and a
// nonzero weight stores an edge, anything else is dropped. The transaction
// with tlast set starts a search from vertex 0 with a double-ended vertex
// queue: a vertex seen for the first time joins at the back, a re-queued one
// at the front. The search is run by one adder/comparator under a small
// sequencer: each pop steps through ST_POP, ST_POP_WAIT and ST_DIST_U, then
// each vertex in use other than the popped one takes a scan step (edge and
// distance memory read) and an eval step (relax). Results then leave on the
// master stream, one distance per vertex in use, vertex 0 first, each read,
// loaded and then held until m_tready; all ones marks an unreachable vertex.
// After the last result, and once after reset, the edge memory is swept to
// zero at one entry per cycle over all MAX_VERTICES*MAX_VERTICES entries
// (1024 by default), during which s_tready stays low. vertex_count may only
// be written while the block is idle; 0 acts as 1 and values above
// MAX_VERTICES act as MAX_VERTICES.
// ----------------------------------------------------------------------------
module single_source_shortest_path_pape
    import ssp_pkg::*;
#(
    parameter int MAX_VERTICES  = 32,
    parameter int WEIGHT_BITS   = 16,
    parameter int DISTANCE_BITS = 24
)
(
    input  logic clk,
    input  logic rst_n,
    // vertex_count register write
    input  logic                                   cfg_we,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]      cfg_wdata,
    // matrix entry stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // row_index, col_index, edge_weight, zero fill
    input  logic [((2*$clog2(MAX_VERTICES)+WEIGHT_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                                   s_tlast,   // last_entry
    // result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // vertex_index, path_length, zero fill
    output logic [(($clog2(MAX_VERTICES)+DISTANCE_BITS+7)/8)*8-1:0] m_tdata,
    output logic                                   m_tlast    // last_result
);

    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int CW     = $clog2(MAX_VERTICES + 1);
    localparam int AW     = $clog2(MAX_VERTICES * MAX_VERTICES);
    localparam int OUT_W  = ((VW + DISTANCE_BITS + 7) / 8) * 8;
    localparam int SUMW   = ((DISTANCE_BITS > WEIGHT_BITS) ? DISTANCE_BITS : WEIGHT_BITS) + 1;

    localparam logic [CW-1:0]            N_MAX     = CW'(MAX_VERTICES);
    localparam logic [VW-1:0]            V_LAST    = VW'(MAX_VERTICES - 1);
    localparam logic [AW-1:0]            CLR_LAST  = AW'(MAX_VERTICES * MAX_VERTICES - 1);
    localparam logic [DISTANCE_BITS-1:0] DIST_NONE = '1;

    // state
    state_t state_reg, state_next;

    logic [CW-1:0]            count_reg, count_next;     // vertex_count register
    logic [CW-1:0]            n_reg, n_next;             // clamped count for this run
    logic [AW-1:0]            clr_reg, clr_next;
    logic [MAX_VERTICES-1:0]  dvalid_reg, dvalid_next;   // distance entry written this run
    logic [MAX_VERTICES-1:0]  qnow_reg, qnow_next;
    logic [MAX_VERTICES-1:0]  qever_reg, qever_next;
    logic [VW-1:0]            head_reg, head_next;
    logic [CW-1:0]            fill_reg, fill_next;
    logic [VW-1:0]            u_reg, u_next;
    logic [DISTANCE_BITS-1:0] du_reg, du_next;
    logic [CW-1:0]            v_reg, v_next;             // scan and emit counter
    logic                     mvalid_reg, mvalid_next;
    logic [VW-1:0]            mvert_reg, mvert_next;
    logic [DISTANCE_BITS-1:0] mdist_reg, mdist_next;
    logic                     mlast_reg, mlast_next;

    // memory ports
    logic                     e_we;
    logic [AW-1:0]            e_waddr, e_raddr;
    logic [WEIGHT_BITS-1:0]   e_wdata, e_rdata;
    logic                     d_we;
    logic [VW-1:0]            d_waddr, d_raddr;
    logic [DISTANCE_BITS-1:0] d_wdata, d_rdata;
    logic                     q_we;
    logic [VW-1:0]            q_waddr, q_raddr;
    logic [VW-1:0]            q_wdata, q_rdata;

    // input fields
    logic [VW-1:0]          in_row, in_col;
    logic [WEIGHT_BITS-1:0] in_weight;
    logic                   in_accept, in_store;

    assign in_row    = s_tdata[VW-1:0];
    assign in_col    = s_tdata[2*VW-1:VW];
    assign in_weight = s_tdata[2*VW+WEIGHT_BITS-1:2*VW];
    assign in_accept = s_tvalid && s_tready;
    assign in_store  = (in_row < in_col) && (CW'(in_col) < N_MAX) && (in_weight != '0);

    // relax datapath: the one shared adder and comparator
    logic [VW-1:0]            v_idx, lo_idx, hi_idx;
    logic [DISTANCE_BITS-1:0] dv;
    logic [SUMW-1:0]          sum;
    logic [DISTANCE_BITS-1:0] nd;
    logic                     improve;
    logic [CW:0]              tail_sum;
    logic [VW-1:0]            tail_pos, head_dec, head_inc;

    assign v_idx   = v_reg[VW-1:0];
    assign lo_idx  = (u_reg < v_idx) ? u_reg : v_idx;
    assign hi_idx  = (u_reg < v_idx) ? v_idx : u_reg;
    assign dv      = dvalid_reg[v_idx] ? d_rdata : DIST_NONE;
    assign sum     = SUMW'(du_reg) + SUMW'(e_rdata);
    assign nd      = (sum >= SUMW'(DIST_NONE)) ? (DIST_NONE - 1'b1) : sum[DISTANCE_BITS-1:0];
    assign improve = (e_rdata != '0) && (nd < dv);

    // deque positions wrap at the queue depth
    assign tail_sum = (CW+1)'(head_reg) + (CW+1)'(fill_reg);
    assign tail_pos = (tail_sum >= (CW+1)'(MAX_VERTICES))
                    ? VW'(tail_sum - (CW+1)'(MAX_VERTICES)) : VW'(tail_sum);
    assign head_dec = (head_reg == '0) ? V_LAST : (head_reg - 1'b1);
    assign head_inc = (head_reg == V_LAST) ? '0 : (head_reg + 1'b1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (in_accept && s_tlast)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:     state_next = ST_POP;
            ST_POP:       state_next = (fill_reg == '0) ? ST_EMIT_RD : ST_POP_WAIT;
            ST_POP_WAIT:  state_next = ST_DIST_U;
            ST_DIST_U:    state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (v_reg == n_reg)
                begin
                    state_next = ST_POP;
                end
                else if (v_idx != u_reg)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:      state_next = ST_SCAN;
            ST_EMIT_RD:   state_next = ST_EMIT_LD;
            ST_EMIT_LD:   state_next = ST_EMIT_HOLD;
            ST_EMIT_HOLD:
            begin
                if (m_tready)
                begin
                    state_next = mlast_reg ? ST_CLEAR : ST_EMIT_RD;
                end
            end
            default:      state_next = ST_CLEAR;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        count_next  = cfg_we ? cfg_wdata : count_reg;
        n_next      = n_reg;
        clr_next    = clr_reg;
        dvalid_next = dvalid_reg;
        qnow_next   = qnow_reg;
        qever_next  = qever_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        u_next      = u_reg;
        du_next     = du_reg;
        v_next      = v_reg;
        mvalid_next = mvalid_reg;
        mvert_next  = mvert_reg;
        mdist_next  = mdist_reg;
        mlast_next  = mlast_reg;

        e_we    = 1'b0;
        e_waddr = AW'(in_row) * AW'(MAX_VERTICES) + AW'(in_col);
        e_wdata = in_weight;
        e_raddr = AW'(lo_idx) * AW'(MAX_VERTICES) + AW'(hi_idx);
        d_we    = 1'b0;
        d_waddr = v_idx;
        d_wdata = nd;
        d_raddr = v_idx;
        q_we    = 1'b0;
        q_waddr = tail_pos;
        q_wdata = v_idx;
        q_raddr = head_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // sweep the edge memory back to no edges
                e_we     = 1'b1;
                e_waddr  = clr_reg;
                e_wdata  = '0;
                clr_next = (clr_reg == CLR_LAST) ? '0 : (clr_reg + 1'b1);
            end
            ST_LOAD:
            begin
                e_we = in_accept && in_store;
                if (count_reg == '0)
                begin
                    n_next = CW'(1);
                end
                else if (count_reg > N_MAX)
                begin
                    n_next = N_MAX;
                end
                else
                begin
                    n_next = count_reg;
                end
            end
            ST_START:
            begin
                // source at distance zero, queued at the back
                d_we        = 1'b1;
                d_waddr     = '0;
                d_wdata     = '0;
                dvalid_next = '0;
                dvalid_next[0] = 1'b1;
                qnow_next   = '0;
                qnow_next[0] = 1'b1;
                qever_next  = '0;
                qever_next[0] = 1'b1;
                q_we        = 1'b1;
                q_waddr     = '0;
                q_wdata     = '0;
                head_next   = '0;
                fill_next   = CW'(1);
            end
            ST_POP:
            begin
                if (fill_reg != '0)
                begin
                    head_next = head_inc;
                    fill_next = fill_reg - 1'b1;
                end
                v_next = '0;
            end
            ST_POP_WAIT:
            begin
                u_next            = q_rdata;
                qnow_next[q_rdata] = 1'b0;
                d_raddr           = q_rdata;
            end
            ST_DIST_U:
            begin
                du_next = dvalid_reg[u_reg] ? d_rdata : DIST_NONE;
                v_next  = '0;
            end
            ST_SCAN:
            begin
                if ((v_reg != n_reg) && (v_idx == u_reg))
                begin
                    v_next = v_reg + 1'b1;
                end
            end
            ST_EVAL:
            begin
                if (improve)
                begin
                    d_we               = 1'b1;
                    dvalid_next[v_idx] = 1'b1;
                    if (!qnow_reg[v_idx] && (fill_reg < N_MAX))
                    begin
                        q_we              = 1'b1;
                        fill_next         = fill_reg + 1'b1;
                        qnow_next[v_idx]  = 1'b1;
                        qever_next[v_idx] = 1'b1;
                        if (qever_reg[v_idx])
                        begin
                            q_waddr   = head_dec;
                            head_next = head_dec;
                        end
                    end
                end
                v_next = v_reg + 1'b1;
            end
            ST_EMIT_RD:
            begin
                d_raddr = v_idx;
            end
            ST_EMIT_LD:
            begin
                mvalid_next = 1'b1;
                mvert_next  = v_idx;
                mdist_next  = dvalid_reg[v_idx] ? d_rdata : DIST_NONE;
                mlast_next  = ((v_reg + 1'b1) == n_reg);
            end
            ST_EMIT_HOLD:
            begin
                if (m_tready)
                begin
                    mvalid_next = 1'b0;
                    v_next      = v_reg + 1'b1;
                    if (mlast_reg)
                    begin
                        clr_next = '0;
                    end
                end
            end
            default:
            begin
                clr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            count_reg  <= N_MAX;
            n_reg      <= N_MAX;
            clr_reg    <= '0;
            dvalid_reg <= '0;
            qnow_reg   <= '0;
            qever_reg  <= '0;
            head_reg   <= '0;
            fill_reg   <= '0;
            v_reg      <= '0;
            mvalid_reg <= 1'b0;
            mlast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            n_reg      <= n_next;
            clr_reg    <= clr_next;
            dvalid_reg <= dvalid_next;
            qnow_reg   <= qnow_next;
            qever_reg  <= qever_next;
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            v_reg      <= v_next;
            mvalid_reg <= mvalid_next;
            mlast_reg  <= mlast_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        u_reg     <= u_next;
        du_reg    <= du_next;
        mvert_reg <= mvert_next;
        mdist_reg <= mdist_next;
    end

    // edge memory: upper triangle at row*MAX_VERTICES+col
    ssp_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_VERTICES * MAX_VERTICES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    // distance table, entries without a valid bit read as unreachable
    ssp_ram #(
        .WIDTH (DISTANCE_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // double-ended vertex queue
    ssp_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_deque_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = mvalid_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = OUT_W'({mdist_reg, mvert_reg});

endmodule
